@@ hdl/assert_macros.svh @@
// Assertion helper macros for the RTL.
// Expects clk and rst_n (synchronous, active low) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/thsm_pkg.sv @@
// Shared types and constants for the trigger history sequence matcher.
// No dependencies.
package thsm_pkg;

  localparam logic [1:0] ACT_RECORD   = 2'd0;
  localparam logic [1:0] ACT_PRESENCE = 2'd1;
  localparam logic [1:0] ACT_SEQUENCE = 2'd2;

  localparam logic KIND_PRESENCE = 1'b0;
  localparam logic KIND_SEQUENCE = 1'b1;

  localparam logic [31:0] RETENTION_RESET = 32'd60000;

  typedef struct packed {
    logic [15:0] trig_id;
    logic [7:0]  player;
    logic [31:0] tstamp;
  } hist_entry_t;

endpackage

@@ hdl/trigger_history_sequence_matcher_top.sv @@
// Trigger history sequence matcher: event ring in one synchronous RAM plus
// a small RAM of pending sequence ids. Depends on thsm_pkg, assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall): one item per transfer. The block
//   stalls the input while it works on an item; action 0 records an event,
//   1 asks for presence of an id, 2 loads one sequence id (last=1 runs the
//   sequence search). Results leave on the out_ channel, at most one per item.
//   Config channel (cfg_valid/cfg_ready): writes retention_ms; always ready,
//   to be written only while the block is idle.
// Flow per item: accept, then a read and a check for each pruned entry, a last prune
//   check that ends pruning, then the action; a record ends there.
//   Queries walk the history RAM one entry per cycle, newest first, drain the last read
//   and pass the result through the output stage.
//   A sequence first fetches the last id loaded, and after each matched id reloads the
//   next id and resumes the walk below the matched entry. The RAM read port sets the pace.
// Reset clears ring pointers, counts, the pending sequence and retention
//   (60000 ms); RAM contents are not cleared and need no clearing pass.
// A stalled result stays in the output register; the next item is still
//   accepted, and only its own result waits until the register frees up.
module trigger_history_sequence_matcher_top #(
  parameter int HISTORY_DEPTH = 64,
  parameter int MAX_SEQUENCE  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_trigger_id,
  input  logic [7:0]  in_player,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_window_ms,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic        out_query_kind,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int CW  = $clog2(HISTORY_DEPTH + 1);
  localparam int SAW = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1;
  localparam int LW  = $clog2(MAX_SEQUENCE + 1);

  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
  localparam logic [LW-1:0] MAX_C = LW'(MAX_SEQUENCE);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_PRUNE_RD  = 3'd1;
  localparam logic [2:0] S_PRUNE_CHK = 3'd2;
  localparam logic [2:0] S_ACT       = 3'd3;
  localparam logic [2:0] S_SEQ_LOAD  = 3'd4;
  localparam logic [2:0] S_WALK      = 3'd5;
  localparam logic [2:0] S_SEQ_FIN   = 3'd6;
  localparam logic [2:0] S_RESP      = 3'd7;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) sum = sum - DEPTH_W;
    return sum[AW-1:0];
  endfunction

  // Memories
  thsm_pkg::hist_entry_t hist_mem [HISTORY_DEPTH];
  thsm_pkg::hist_entry_t hist_rd_q;
  logic [15:0]           seq_mem [MAX_SEQUENCE];
  logic [15:0]           seq_rd_q;

  logic                  hist_re;
  logic [AW-1:0]         hist_raddr;
  logic                  hist_we;
  logic [AW-1:0]         hist_waddr;
  thsm_pkg::hist_entry_t hist_wdata;
  logic                  seq_we;
  logic                  seq_re;
  logic [SAW-1:0]        seq_raddr;

  // Control and item registers
  logic [2:0]    state_r, state_nxt;
  logic [1:0]    act_r;
  logic [15:0]   id_r;
  logic [7:0]    pl_r;
  logic [31:0]   now_r;
  logic [31:0]   win_r;
  logic          last_r;
  logic [31:0]   ret_r, ret_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [LW-1:0] seq_len_r, seq_len_nxt;
  logic [LW-1:0] next_r, next_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          pend_r, pend_nxt;
  logic          have_newest_r, have_newest_nxt;
  logic [31:0]   newest_r, newest_nxt;
  logic [31:0]   first_t_r, first_t_nxt;
  logic          res_found_r, res_found_nxt;
  logic          res_kind_r, res_kind_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r, out_found_nxt;
  logic          out_kind_r, out_kind_nxt;

  logic          in_xfer;
  logic          out_free;
  logic [CW-1:0] km1;
  logic [15:0]   target;
  logic          entry_match;
  logic          win_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_query_kind = out_kind_r;

  assign seq_we = in_xfer && (in_action == thsm_pkg::ACT_SEQUENCE) && (seq_len_r < MAX_C);

  assign km1    = k_r - CW'(1);
  assign target = (act_r == thsm_pkg::ACT_SEQUENCE) ? seq_rd_q : id_r;
  assign entry_match = (hist_rd_q.player == pl_r) && (hist_rd_q.trig_id == target);
  assign win_ok = (win_r == 32'd0) || ((now_r - hist_rd_q.tstamp) <= win_r);

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (hist_re) hist_rd_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (seq_we) seq_mem[seq_len_r[SAW-1:0]] <= in_trigger_id;
    if (seq_re) seq_rd_q <= seq_mem[seq_raddr];
  end

  always_comb begin
    state_nxt       = state_r;
    ret_nxt         = ret_r;
    oldest_nxt      = oldest_r;
    count_nxt       = count_r;
    seq_len_nxt     = seq_len_r;
    next_nxt        = next_r;
    k_nxt           = k_r;
    pend_nxt        = pend_r;
    have_newest_nxt = have_newest_r;
    newest_nxt      = newest_r;
    first_t_nxt     = first_t_r;
    res_found_nxt   = res_found_r;
    res_kind_nxt    = res_kind_r;
    out_valid_nxt   = out_valid_r;
    out_found_nxt   = out_found_r;
    out_kind_nxt    = out_kind_r;
    hist_re         = 1'b0;
    hist_raddr      = oldest_r;
    hist_we         = 1'b0;
    hist_waddr      = oldest_r;
    hist_wdata      = '{trig_id: id_r, player: pl_r, tstamp: now_r};
    seq_re          = 1'b0;
    seq_raddr       = SAW'(next_r - LW'(1));

    if (cfg_valid && cfg_ready) ret_nxt = cfg_data;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (seq_we) seq_len_nxt = seq_len_r + LW'(1);
          state_nxt = S_PRUNE_RD;
        end
      end
      S_PRUNE_RD: begin
        if (count_r == '0) begin
          state_nxt = S_ACT;
        end else begin
          hist_re   = 1'b1;
          state_nxt = S_PRUNE_CHK;
        end
      end
      S_PRUNE_CHK: begin
        if ((now_r - hist_rd_q.tstamp) > ret_r) begin
          oldest_nxt = (oldest_r == LAST_SLOT) ? '0 : oldest_r + AW'(1);
          count_nxt  = count_r - CW'(1);
          state_nxt  = S_PRUNE_RD;
        end else begin
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        k_nxt           = count_r;
        pend_nxt        = 1'b0;
        have_newest_nxt = 1'b0;
        unique case (act_r)
          thsm_pkg::ACT_RECORD: begin
            hist_we = 1'b1;
            if (count_r == DEPTH_C) begin
              hist_waddr = oldest_r;
              oldest_nxt = (oldest_r == LAST_SLOT) ? '0 : oldest_r + AW'(1);
            end else begin
              hist_waddr = wrap_add(oldest_r, count_r[AW-1:0]);
              count_nxt  = count_r + CW'(1);
            end
            state_nxt = S_IDLE;
          end
          thsm_pkg::ACT_PRESENCE: begin
            res_kind_nxt = thsm_pkg::KIND_PRESENCE;
            state_nxt    = S_WALK;
          end
          thsm_pkg::ACT_SEQUENCE: begin
            if (last_r) begin
              res_kind_nxt = thsm_pkg::KIND_SEQUENCE;
              next_nxt     = seq_len_r;
              seq_len_nxt  = '0;
              state_nxt    = S_SEQ_LOAD;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SEQ_LOAD: begin
        // fetch the id sought next, newest-first order
        seq_re    = 1'b1;
        pend_nxt  = 1'b0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (pend_r && entry_match && (act_r == thsm_pkg::ACT_PRESENCE) && win_ok) begin
          res_found_nxt = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = S_RESP;
        end else if (pend_r && entry_match && (act_r == thsm_pkg::ACT_SEQUENCE)) begin
          if (!have_newest_r) newest_nxt = hist_rd_q.tstamp;
          have_newest_nxt = 1'b1;
          first_t_nxt     = hist_rd_q.tstamp;
          next_nxt        = next_r - LW'(1);
          pend_nxt        = 1'b0;
          // k_r still names the matched entry; resume below it after reload
          state_nxt = (next_r == LW'(1)) ? S_SEQ_FIN : S_SEQ_LOAD;
        end else if (k_r != '0) begin
          hist_re    = 1'b1;
          hist_raddr = wrap_add(oldest_r, km1[AW-1:0]);
          k_nxt      = km1;
          pend_nxt   = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          res_found_nxt = 1'b0;
          state_nxt     = S_RESP;
        end
      end
      S_SEQ_FIN: begin
        res_found_nxt = (win_r == 32'd0) ||
                        (((now_r - newest_r) <= win_r) && ((newest_r - first_t_r) <= win_r));
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_kind_nxt  = res_kind_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ret_r         <= thsm_pkg::RETENTION_RESET;
      oldest_r      <= '0;
      count_r       <= '0;
      seq_len_r     <= '0;
      next_r        <= '0;
      k_r           <= '0;
      pend_r        <= 1'b0;
      have_newest_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ret_r         <= ret_nxt;
      oldest_r      <= oldest_nxt;
      count_r       <= count_nxt;
      seq_len_r     <= seq_len_nxt;
      next_r        <= next_nxt;
      k_r           <= k_nxt;
      pend_r        <= pend_nxt;
      have_newest_r <= have_newest_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r  <= in_action;
      id_r   <= in_trigger_id;
      pl_r   <= in_player;
      now_r  <= in_now_ms;
      win_r  <= in_window_ms;
      last_r <= in_last;
    end
    newest_r    <= newest_nxt;
    first_t_r   <= first_t_nxt;
    res_found_r <= res_found_nxt;
    res_kind_r  <= res_kind_nxt;
    out_found_r <= out_found_nxt;
    out_kind_r  <= out_kind_nxt;
  end

  `ASSERT_ALWAYS(a_count_bound, count_r <= DEPTH_C, "entry count above ring depth")
  `ASSERT_ALWAYS(a_seq_bound, seq_len_r <= MAX_C, "sequence length above limit")
  `ASSERT_ALWAYS(a_walk_bound, (state_r != S_WALK) || (k_r <= count_r),
                 "walk index past entries")
  `ASSERT_NEXT(a_record_grows, (state_r == S_ACT) && (act_r == thsm_pkg::ACT_RECORD),
               count_r != '0, "record left empty ring")
  `ASSERT_NEXT(a_resp_load, (state_r == S_RESP) && out_free,
               out_valid_r && (state_r == S_IDLE), "result not loaded")

endmodule
